### rtl/rpms_pkg.sv
// Shared types, constants and the microcode ROM of the roll plant model step.
package rpms_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned COEFF_W   = 17;
    localparam int unsigned PC_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAG_COEFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_COEFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_COEFF = 2'd2;

    localparam logic [COEFF_W-1:0] LAG_COEFF_RST   = 17'd1311;
    localparam logic [COEFF_W-1:0] VEL_COEFF_RST   = 17'd1311;
    localparam logic [COEFF_W-1:0] ANGLE_COEFF_RST = 17'd66;

    localparam logic signed [31:0] DRIVE_LIM = 32'sd65536000;
    localparam logic signed [33:0] VEL_LIM   = 34'sd2147418112;
    localparam logic signed [33:0] ANGLE_LIM = 34'sd205914112;
    localparam logic signed [48:0] ROUND_BIAS = 49'sd32768;

    // Multiplier operand select
    typedef enum logic [1:0] {
        X_LAG_ERR,
        X_LAG,
        X_VEL
    } x_sel_t;

    // State register update select
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_LAG,
        UPD_VEL,
        UPD_ANG
    } upd_t;

    typedef struct packed {
        logic   mul_en;
        x_sel_t x_sel;
        upd_t   upd;
        logic   wait_out;
        logic   last;
    } ctrl_t;

    // One control word per step
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{mul_en: 1'b0, x_sel: X_LAG_ERR, upd: UPD_NONE, wait_out: 1'b0, last: 1'b0};
        case (pc)
            3'd0: begin w.mul_en = 1'b1; w.x_sel = X_LAG_ERR; end
            3'd1: begin w.upd = UPD_LAG; end
            3'd2: begin w.mul_en = 1'b1; w.x_sel = X_LAG; end
            3'd3: begin w.upd = UPD_VEL; end
            3'd4: begin w.mul_en = 1'b1; w.x_sel = X_VEL; end
            3'd5: begin w.upd = UPD_ANG; w.wait_out = 1'b1; w.last = 1'b1; end
            default: begin w.last = 1'b1; end
        endcase
        return w;
    endfunction

endpackage

### rtl/rpms_seq.sv
// Microcode sequencer: step counter, busy flag and control word fetch.
module rpms_seq
    import rpms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    output logic  busy,
    output logic  step_en,
    output ctrl_t ctrl
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;

    always_comb
    begin
        ctrl    = ucode(pc_reg);
        // hold the final step until the output word slot is free
        step_en = busy_reg && !(ctrl.wait_out && !out_free);
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (step_en)
        begin
            if (ctrl.last)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/rpms_dpath.sv
// Datapath: drive clamp, shared coefficient multiplier and plant state registers.
module rpms_dpath
    import rpms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_d,
    input  logic signed [31:0]  drive_in,
    input  logic                step_en,
    input  ctrl_t               ctrl,
    input  logic [COEFF_W-1:0]  lag_coeff,
    input  logic [COEFF_W-1:0]  vel_coeff,
    input  logic [COEFF_W-1:0]  angle_coeff,
    output logic signed [27:0]  lag_state,
    output logic signed [31:0]  velocity_state,
    output logic signed [28:0]  angle_next
);

    logic signed [26:0] d_reg, d_next;
    logic signed [48:0] prod_reg, prod_next;
    logic signed [27:0] lag_reg, lag_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [28:0] ang_reg, ang_next;

    logic signed [27:0]    lag_err;
    logic signed [31:0]    x_op;
    logic [COEFF_W-1:0]    c_sel;
    logic signed [16:0]    c_op;
    logic signed [48:0]    biased;
    logic signed [32:0]    rnd;
    logic signed [33:0]    lag_sum, vel_sum, ang_sum;

    always_comb
    begin
        if (drive_in > DRIVE_LIM)
            d_next = DRIVE_LIM[26:0];
        else if (drive_in < -DRIVE_LIM)
            d_next = 27'(-DRIVE_LIM);
        else
            d_next = drive_in[26:0];

        lag_err = 28'({d_reg[26], d_reg} - lag_reg);

        case (ctrl.x_sel)
            X_LAG_ERR: begin x_op = 32'(lag_err); c_sel = lag_coeff;   end
            X_LAG:     begin x_op = 32'(lag_reg); c_sel = vel_coeff;   end
            X_VEL:     begin x_op = vel_reg;      c_sel = angle_coeff; end
            default:   begin x_op = '0;           c_sel = '0;          end
        endcase
        c_op      = $signed({1'b0, c_sel[15:0]});
        prod_next = 49'(x_op) * 49'(c_op);

        // round to nearest, ties up: floor(p / 2^16 + 0.5)
        biased = prod_reg + ROUND_BIAS;
        rnd    = biased[48:16];

        lag_sum = 34'(lag_reg) + 34'(rnd);
        vel_sum = 34'(vel_reg) + 34'(rnd);
        ang_sum = 34'(ang_reg) + 34'(rnd);

        if (lag_coeff[16])
            lag_next = 28'(d_reg);
        else
            lag_next = lag_sum[27:0];

        if (vel_coeff[16])
            vel_next = '0;
        else if (vel_sum > VEL_LIM)
            vel_next = VEL_LIM[31:0];
        else if (vel_sum < -VEL_LIM)
            vel_next = 32'(-VEL_LIM);
        else
            vel_next = vel_sum[31:0];

        if (angle_coeff[16])
            ang_next = '0;
        else if (ang_sum > ANGLE_LIM)
            ang_next = ANGLE_LIM[28:0];
        else if (ang_sum < -ANGLE_LIM)
            ang_next = 29'(-ANGLE_LIM);
        else
            ang_next = ang_sum[28:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_d)
            d_reg <= d_next;
        if (step_en && ctrl.mul_en)
            prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg <= '0;
            vel_reg <= '0;
            ang_reg <= '0;
        end
        else if (step_en)
        begin
            case (ctrl.upd)
                UPD_LAG: lag_reg <= lag_next;
                UPD_VEL: vel_reg <= vel_next;
                UPD_ANG: ang_reg <= ang_next;
                default: ;
            endcase
        end
    end

    assign lag_state      = lag_reg;
    assign velocity_state = vel_reg;
    assign angle_next     = ang_next;

endmodule

### rtl/roll_plant_model_step.sv
// A result word is loaded into the output registers by the final microcode step.
// No new drive word is taken until six microcode steps, which share one
// registered multiplier (multiply, then update, for lag, velocity and angle), are done.
// The final step holds while the previous result word is still stalled.
// Reset clears the plant state, loads coefficient reset values, empties the output.
module roll_plant_model_step
    import rpms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   drive_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [28:0]   angle_out,
    output logic signed [31:0]   velocity_out,
    output logic signed [26:0]   accel_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_wdata
);

    logic [COEFF_W-1:0] lag_coeff_reg, vel_coeff_reg, angle_coeff_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [28:0] angle_out_reg;
    logic signed [31:0] velocity_out_reg;
    logic signed [26:0] accel_out_reg;

    logic               busy, step_en, in_accept, out_free, out_load;
    ctrl_t              ctrl;
    logic signed [27:0] lag_state;
    logic signed [31:0] velocity_state;
    logic signed [28:0] angle_next;

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = step_en && (ctrl.upd == UPD_ANG);

    rpms_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .out_free (out_free),
        .busy     (busy),
        .step_en  (step_en),
        .ctrl     (ctrl)
    );

    rpms_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_d         (in_accept),
        .drive_in       (drive_in),
        .step_en        (step_en),
        .ctrl           (ctrl),
        .lag_coeff      (lag_coeff_reg),
        .vel_coeff      (vel_coeff_reg),
        .angle_coeff    (angle_coeff_reg),
        .lag_state      (lag_state),
        .velocity_state (velocity_state),
        .angle_next     (angle_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_coeff_reg   <= LAG_COEFF_RST;
            vel_coeff_reg   <= VEL_COEFF_RST;
            angle_coeff_reg <= ANGLE_COEFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAG_COEFF:   lag_coeff_reg   <= cfg_wdata;
                REG_VEL_COEFF:   vel_coeff_reg   <= cfg_wdata;
                REG_ANGLE_COEFF: angle_coeff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            angle_out_reg    <= angle_next;
            velocity_out_reg <= velocity_state;
            accel_out_reg    <= lag_state[26:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign angle_out    = angle_out_reg;
    assign velocity_out = velocity_out_reg;
    assign accel_out    = accel_out_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer not busy after accepting a word");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid || !out_stall))
        else $error("result word overwritten while stalled");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (34'(angle_out) <= ANGLE_LIM) && (34'(angle_out) >= -ANGLE_LIM))
        else $error("angle result out of range");
`endif

endmodule
